/* src/ecc_pkg.sv */
// Shared types, codes and constants of the elevator car controller.
`default_nettype none
package ecc_pkg;

  localparam int CAPACITY = 9;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [7:0] STOP_TICKS     = 8'd2;
  localparam logic [7:0] TRAVEL_RESET   = 8'd5;
  localparam logic [6:0] TOP_RESET      = 7'd99;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_BOARD  = 2'd1;
  localparam logic [1:0] OP_UNLOAD = 2'd2;

  localparam logic REG_TRAVEL = 1'b0;
  localparam logic REG_TOP    = 1'b1;

  typedef enum logic [1:0] {
    MODE_STOPPED  = 2'd0,
    MODE_STOPPING = 2'd1,
    MODE_UP       = 2'd2,
    MODE_DOWN     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_COUNT,
    S_WALK,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        call_valid;
    logic [6:0]  call_floor;
    logic        pass_on_next;
    logic [6:0]  dest_floor;
    logic [15:0] passenger_tag;
    logic [6:0]  unload_floor;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  car_mode;
    logic [1:0]  prior_mode;
    logic [6:0]  car_floor;
    logic [7:0]  time_in_mode;
    logic [3:0]  aboard;
    logic        board_accepted;
    logic        unloaded_valid;
    logic [15:0] unloaded_tag;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [6:0]       dest;
    logic [15:0]      tag;
  } store_wr_t;

endpackage
`default_nettype wire

/* src/ecc_channels.sv */
// Valid/ready channel interfaces for input and result items.
`default_nettype none
interface ecc_in_if;
  import ecc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ecc_out_if;
  import ecc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/elevator_car_controller_top.sv */
// Top level of the elevator car controller: sequencer, car state and config port.
//
//   channel   direction  handshake          payload
//   in_ch     in         valid/ready        opcode, call and boarding fields
//   out_ch    out        valid/ready        car status, unloaded tag, last
//   apb       in/out     psel/penable/pready travel_ticks, top_floor
//
// A tick, a boarding or an unknown opcode passes from acceptance through
// S_EXEC and S_RESULT back to S_IDLE, and S_RESULT waits for the result
// register to be free. An unload counts matches in S_COUNT and, when any
// riders leave, walks the store in S_WALK: one comparator on the store's read
// port scans the riders once to count matches and once to compact the store
// and emit each leaving rider. A stalled result holds the sequencer in place.
// Reset is synchronous; the rider store needs no clearing.
`default_nettype none
module elevator_car_controller_top (
  input  wire logic        clk,
  input  wire logic        rst,
  ecc_in_if.sink           in_ch,
  ecc_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import ecc_pkg::*;

  state_t state, state_next;
  in_item_t item;

  logic [7:0] travel_ticks;
  logic [6:0] top_floor;

  mode_t      mode, mode_next;
  mode_t      prior, prior_next;
  logic [6:0] floor_now, floor_now_next;
  logic [7:0] mode_timer, mode_timer_next;
  logic [CNT_W-1:0] rider_count;

  logic [CNT_W-1:0] idx, keep, ngone, emitted, scan_end;
  logic acc_flag;

  logic      out_valid;
  out_item_t out_data, out_next;
  logic      out_load, slot_free;

  store_wr_t  wr;
  logic [6:0]  rd_dest, front_dest;
  logic [15:0] rd_tag;
  logic        match, room, in_fire;

  ecc_rider_store u_store (
    .clk        (clk),
    .wr         (wr),
    .rd_idx     (idx[IDX_W-1:0]),
    .rd_dest    (rd_dest),
    .rd_tag     (rd_tag),
    .front_dest (front_dest)
  );

  // The one shared comparator of the unload scans.
  assign match     = (rd_dest == item.unload_floor);
  assign room      = (rider_count < CNT_W'(CAPACITY));
  assign slot_free = !out_valid || out_ch.ready;
  assign in_fire   = in_ch.valid && in_ch.ready;

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  // Configuration port.
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      REG_TRAVEL: prdata = {24'd0, travel_ticks};
      REG_TOP:    prdata = {25'd0, top_floor};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      travel_ticks <= TRAVEL_RESET;
      top_floor    <= TOP_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_TOP) top_floor <= pwdata[6:0];
      else travel_ticks <= pwdata[7:0];
    end
  end

  // Mode advance for one tick.
  logic [7:0] floor_up;
  logic       up_ok;
  logic [6:0] target;
  logic       blocked;

  always_comb begin
    floor_up        = {1'b0, floor_now} + 8'd1;
    up_ok           = (floor_up <= {1'b0, top_floor});
    mode_next       = mode;
    prior_next      = prior;
    floor_now_next  = floor_now;
    mode_timer_next = mode_timer;
    target          = (rider_count == '0) ? item.call_floor : front_dest;
    blocked         = (rider_count != '0) && (front_dest > top_floor);
    if (item.call_valid || rider_count != '0) begin
      unique case (mode)
        MODE_STOPPED: begin
          if (!blocked) begin
            if (floor_now > target) begin
              mode_next       = MODE_DOWN;
              mode_timer_next = '0;
            end else if (floor_now < target) begin
              mode_next       = MODE_UP;
              mode_timer_next = '0;
            end
          end
        end
        MODE_STOPPING: begin
          if (mode_timer < STOP_TICKS) begin
            mode_timer_next = mode_timer + 8'd1;
          end else begin
            mode_next       = MODE_STOPPED;
            mode_timer_next = '0;
            if (prior == MODE_UP) begin
              if (up_ok) floor_now_next = floor_up[6:0];
            end else if (floor_now != '0) begin
              floor_now_next = floor_now - 7'd1;
            end
          end
        end
        MODE_UP: begin
          if (mode_timer < travel_ticks) begin
            mode_timer_next = mode_timer + 8'd1;
          end else if (item.pass_on_next ||
                       (rider_count != '0 && floor_up == {1'b0, front_dest})) begin
            prior_next      = MODE_UP;
            mode_next       = MODE_STOPPING;
            mode_timer_next = '0;
          end else if (up_ok) begin
            floor_now_next  = floor_up[6:0];
            mode_timer_next = '0;
          end else begin
            mode_next       = MODE_STOPPING;
            mode_timer_next = '0;
          end
        end
        MODE_DOWN: begin
          if (mode_timer < travel_ticks) begin
            mode_timer_next = mode_timer + 8'd1;
          end else if (item.pass_on_next ||
                       (rider_count != '0 && floor_now != '0 &&
                        floor_now - 7'd1 == front_dest)) begin
            prior_next      = MODE_DOWN;
            mode_next       = MODE_STOPPING;
            mode_timer_next = '0;
          end else if (floor_now != '0) begin
            floor_now_next  = floor_now - 7'd1;
            mode_timer_next = '0;
          end else begin
            mode_next       = MODE_STOPPING;
            mode_timer_next = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) state_next = (in_ch.data.opcode == OP_UNLOAD) ? S_COUNT : S_EXEC;
      end
      S_EXEC:   state_next = S_RESULT;
      S_COUNT: begin
        if (idx == rider_count) state_next = (ngone == '0) ? S_RESULT : S_WALK;
      end
      S_WALK: begin
        if (idx == scan_end) state_next = S_IDLE;
      end
      S_RESULT: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: store writes and result loads.
  always_comb begin
    wr                      = '0;
    out_load                = 1'b0;
    out_next                = '0;
    out_next.car_mode       = mode;
    out_next.prior_mode     = prior;
    out_next.car_floor      = floor_now;
    out_next.time_in_mode   = mode_timer;
    out_next.aboard         = 4'(rider_count);
    unique case (state)
      S_EXEC: begin
        if (item.opcode == OP_BOARD && room) begin
          wr.en   = 1'b1;
          wr.idx  = rider_count[IDX_W-1:0];
          wr.dest = item.dest_floor;
          wr.tag  = item.passenger_tag;
        end
      end
      S_WALK: begin
        if (idx != scan_end) begin
          if (!match) begin
            wr.en   = 1'b1;
            wr.idx  = keep[IDX_W-1:0];
            wr.dest = rd_dest;
            wr.tag  = rd_tag;
          end else if (slot_free) begin
            out_load                = 1'b1;
            out_next.unloaded_valid = 1'b1;
            out_next.unloaded_tag   = rd_tag;
            out_next.last           = (emitted + CNT_W'(1) == ngone);
          end
        end
      end
      S_RESULT: begin
        if (slot_free) begin
          out_load                = 1'b1;
          out_next.board_accepted = acc_flag;
          out_next.last           = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control and car state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      mode        <= MODE_STOPPED;
      prior       <= MODE_STOPPED;
      floor_now   <= '0;
      mode_timer  <= '0;
      rider_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_EXEC: begin
          if (item.opcode == OP_TICK) begin
            mode       <= mode_next;
            prior      <= prior_next;
            floor_now  <= floor_now_next;
            mode_timer <= mode_timer_next;
          end
          if (item.opcode == OP_BOARD && room) rider_count <= rider_count + CNT_W'(1);
        end
        S_COUNT: begin
          // The final count is shown on every result of the unload.
          if (idx == rider_count) rider_count <= rider_count - ngone;
        end
        default: ;
      endcase
    end
  end

  // Scan counters, captured item and result register.
  always_ff @(posedge clk) begin
    if (out_load) out_data <= out_next;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          item     <= in_ch.data;
          idx      <= '0;
          ngone    <= '0;
          acc_flag <= 1'b0;
        end
      end
      S_EXEC: begin
        if (item.opcode == OP_BOARD && room) acc_flag <= 1'b1;
      end
      S_COUNT: begin
        if (idx != rider_count) begin
          if (match) ngone <= ngone + CNT_W'(1);
          idx <= idx + CNT_W'(1);
        end else begin
          scan_end <= rider_count;
          idx      <= '0;
          keep     <= '0;
          emitted  <= '0;
        end
      end
      S_WALK: begin
        if (idx != scan_end) begin
          if (!match) begin
            keep <= keep + CNT_W'(1);
            idx  <= idx + CNT_W'(1);
          end else if (slot_free) begin
            emitted <= emitted + CNT_W'(1);
            idx     <= idx + CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* src/ecc_rider_store.sv */
// Ordered store of boarded riders: one write port, one indexed read, front entry.
`default_nettype none
module ecc_rider_store (
  input  wire logic                    clk,
  input  wire ecc_pkg::store_wr_t      wr,
  input  wire logic [ecc_pkg::IDX_W-1:0] rd_idx,
  output logic [6:0]                   rd_dest,
  output logic [15:0]                  rd_tag,
  output logic [6:0]                   front_dest
);
  import ecc_pkg::*;

  logic [6:0]  dest_mem [CAPACITY];
  logic [15:0] tag_mem  [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      dest_mem[wr.idx] <= wr.dest;
      tag_mem[wr.idx]  <= wr.tag;
    end
  end

  // An index past the last entry reads as zero rather than off the array.
  always_comb begin
    if (32'(rd_idx) < CAPACITY) begin
      rd_dest = dest_mem[rd_idx];
      rd_tag  = tag_mem[rd_idx];
    end else begin
      rd_dest = '0;
      rd_tag  = '0;
    end
  end

  assign front_dest = dest_mem[0];

endmodule
`default_nettype wire

/* src/ecc_checker.sv */
// Port-level assertions for the elevator car controller, bound to the top level.
`default_nettype none
module ecc_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire ecc_pkg::out_item_t out_data
);
  import ecc_pkg::*;

  // A held result must not change while it waits.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Each item is worked on alone, so acceptance is never followed at once by another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is at work");

  a_aboard_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(out_data.aboard) <= CAPACITY)
    else $error("more riders aboard than the car holds");

  a_board_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.board_accepted |-> out_data.last && !out_data.unloaded_valid)
    else $error("accepted boarding not a single plain result");

  a_tag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.unloaded_valid |-> out_data.unloaded_tag == '0 && out_data.last)
    else $error("status result carries a tag or is not last");

endmodule

bind elevator_car_controller_top ecc_checker u_ecc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
`default_nettype wire
